@@ design/spsh_pkg.sv @@
// Shared constants, widths and the arctangent table for the sweep path heading controller.
// No dependencies; imported by every module of the block.
package spsh_pkg;

    localparam int MAX_PASSES_DEF = 255;
    localparam int WW             = 24;  // working width of leg arithmetic
    localparam int KW             = 19;  // step times pass count
    localparam int CXW            = 42;  // CORDIC vector width
    localparam int CZW            = 24;  // CORDIC angle width, 1/25600 degree
    localparam int MW             = 23;  // magnitude of numerator and denominator
    localparam int AW             = 14;  // arctangent magnitude, 0.01 degree
    localparam int CORDIC_STEPS   = 16;
    localparam int ZMAX           = 2304000;
    localparam longint RECIP_100  = 171798692;  // ceil(2^34 / 100)
    localparam int RECIP_SHIFT    = 34;

    function automatic logic [CZW-1:0] atan_entry(input logic [3:0] idx);
        logic [CZW-1:0] v;
        unique case (idx)
            4'd0:    v = CZW'(1152000);
            4'd1:    v = CZW'(680065);
            4'd2:    v = CZW'(359328);
            4'd3:    v = CZW'(182400);
            4'd4:    v = CZW'(91554);
            4'd5:    v = CZW'(45822);
            4'd6:    v = CZW'(22916);
            4'd7:    v = CZW'(11459);
            4'd8:    v = CZW'(5730);
            4'd9:    v = CZW'(2865);
            4'd10:   v = CZW'(1432);
            4'd11:   v = CZW'(716);
            4'd12:   v = CZW'(358);
            4'd13:   v = CZW'(179);
            4'd14:   v = CZW'(90);
            default: v = CZW'(45);
        endcase
        return v;
    endfunction

endpackage

@@ design/spsh_cordic.sv @@
// Iterative vectoring CORDIC: one rotation per cycle, one rotation per angle table entry for each arctangent.
// Depends on spsh_pkg for widths and the angle table.
module spsh_cordic (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [spsh_pkg::MW-1:0] i_num_mag,
    input  logic [spsh_pkg::MW-1:0] i_den_mag,
    output logic                   o_done,
    output logic [spsh_pkg::AW-1:0] o_mag
);
    import spsh_pkg::*;

    logic signed [CXW-1:0] r_x, r_y, n_x, n_y;
    logic signed [CZW-1:0] r_z, n_z;
    logic [3:0]            r_i;
    logic                  r_busy, r_done;
    logic signed [CZW-1:0] z_clamp;
    logic signed [CZW:0]   z_round;

    always_comb begin
        if (r_y > 0) begin
            n_x = r_x + (r_y >>> r_i);
            n_y = r_y - (r_x >>> r_i);
            n_z = r_z + $signed(atan_entry(r_i));
        end else begin
            n_x = r_x - (r_y >>> r_i);
            n_y = r_y + (r_x >>> r_i);
            n_z = r_z - $signed(atan_entry(r_i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= $signed({{(CXW-MW-16){1'b0}}, i_den_mag, 16'd0});
                r_y    <= $signed({{(CXW-MW-16){1'b0}}, i_num_mag, 16'd0});
                r_z    <= '0;
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_i <= r_i + 4'd1;
                if (r_i == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_z < 0)
            z_clamp = '0;
        else if (r_z > CZW'(ZMAX))
            z_clamp = CZW'(ZMAX);
        else
            z_clamp = r_z;
        z_round = {1'b0, z_clamp} + (CZW+1)'(128);
    end

    assign o_mag  = AW'(z_round >>> 8);
    assign o_done = r_done;

endmodule

@@ design/sweep_path_heading_controller.sv @@
// Top level of the sweep path heading controller: leg sequencer, config registers, drive math.
// Depends on spsh_pkg and spsh_cordic.
//
// Usage:
//   Slave stream takes one pose beat (x, y, heading). Master stream returns one beat with the
//   two drive commands, the wrapped heading error, the leg and the pass count.
//   APB port writes pass_step_x, pass_step_y, steer_gain, base_speed at 0x0, 0x4, 0x8, 0xC.
//   Handshake: one pose at a time; a new pose is taken only after the sequencer has returned
//   to idle with the previous result.
//   Each pose runs through the sixteen rotations of the single CORDIC plus setup, scaling and
//   the reciprocal multiply steps of the sequencer.
//   o_s_tready is high only while the sequencer idles; a finished result waits in the output
//   register, and the next pose is accepted meanwhile. If the receiver stalls, the sequencer
//   holds its last step until the output register frees.
//   Reset: leg 0, zero passes, zero last aim, registers at 100, 100, 200, 0; no beat pending.
module sweep_path_heading_controller #(
    parameter int MAX_PASSES = spsh_pkg::MAX_PASSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // pos_x[15:0], pos_y[31:16], heading[47:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,  // left_drive[20:0], right_drive[41:21],
                                    // heading_error[58:42], leg_now[60:59], passes_done[68:61]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spsh_pkg::*;

    localparam int PASS_CAP = (MAX_PASSES < 255) ? MAX_PASSES : 255;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_LEG   = 4'd2;
    localparam logic [3:0] ST_ND    = 4'd3;
    localparam logic [3:0] ST_CST   = 4'd4;
    localparam logic [3:0] ST_CWAIT = 4'd5;
    localparam logic [3:0] ST_AIM   = 4'd6;
    localparam logic [3:0] ST_PROD  = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    localparam logic [1:0] REG_SX   = 2'd0;
    localparam logic [1:0] REG_SY   = 2'd1;
    localparam logic [1:0] REG_GAIN = 2'd2;
    localparam logic [1:0] REG_BASE = 2'd3;

    logic [3:0]  r_state;
    logic [9:0]  r_sx, r_sy, r_gain;
    logic [16:0] r_base;
    logic [1:0]  r_leg, r_op_leg;
    logic [7:0]  r_pass;
    logic signed [16:0] r_last;
    logic signed [15:0] r_x, r_y, r_h;
    logic [KW-1:0] r_sxk, r_syk;
    logic signed [WW-1:0] r_num, r_den;
    logic r_keep, r_dxpos;
    logic signed [14:0] r_t;
    logic signed [17:0] r_err;
    logic [24:0] r_prod;
    logic        r_neg;
    logic [17:0] r_q;
    logic        r_out_valid;
    logic [71:0] r_out;

    logic signed [WW-1:0] xs, ys, sxk, syk, d1, d2, num_c, den_c;
    logic [MW-1:0] num_mag, den_mag;
    logic          c_done;
    logic [AW-1:0] c_mag;
    logic signed [16:0] aim;
    logic signed [17:0] err_raw, err_w;
    logic [16:0]        err_abs;
    logic [52:0]        recip_p;
    logic signed [18:0] q_s;
    logic signed [20:0] left_d, right_d;
    logic               wr_en;

    assign xs  = WW'(r_x);
    assign ys  = WW'(r_y);
    assign sxk = $signed({{(WW-KW){1'b0}}, r_sxk});
    assign syk = $signed({{(WW-KW){1'b0}}, r_syk});

    assign wr_en = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_SX:   prdata = {22'd0, r_sx};
            REG_SY:   prdata = {22'd0, r_sy};
            REG_GAIN: prdata = {22'd0, r_gain};
            REG_BASE: prdata = {15'd0, r_base};
            default:  prdata = '0;
        endcase
    end

    always_comb begin
        unique case (r_op_leg)
            2'd0: begin
                d1 = xs - WW'(600) - sxk;
                d2 = ys - WW'(3200) - syk;
            end
            2'd1: begin
                d1 = ys - WW'(3767) - syk;
                d2 = xs + WW'(400) + sxk;
            end
            2'd2: begin
                d1 = xs + WW'(600) + sxk;
                d2 = ys - WW'(1600) + syk;
            end
            default: begin
                d1 = ys - WW'(1400) + syk;
                d2 = xs - WW'(400) - sxk;
            end
        endcase
        num_c = d1 + (d1 <<< 1);
        den_c = d2 <<< 1;
    end

    assign num_mag = MW'(r_num < 0 ? -r_num : r_num);
    assign den_mag = MW'(r_den < 0 ? -r_den : r_den);

    spsh_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == ST_CST),
        .i_num_mag (num_mag),
        .i_den_mag (den_mag),
        .o_done    (c_done),
        .o_mag     (c_mag)
    );

    always_comb begin
        unique case (r_op_leg)
            2'd0: aim = -17'(r_t);
            2'd1: aim = 17'(9000) + 17'(r_t);
            2'd2: begin
                if (r_keep)
                    aim = r_last;
                else if (r_dxpos)
                    aim = 17'(18000) - 17'(r_t);
                else
                    aim = -17'(18000) - 17'(r_t);
            end
            default: aim = -17'(9000) + 17'(r_t);
        endcase
        err_raw = 18'(aim) - 18'(r_h);
        if (err_raw > 18'sd18000)
            err_w = err_raw - 18'sd36000;
        else if (err_raw < -18'sd18000)
            err_w = err_raw + 18'sd36000;
        else
            err_w = err_raw;
    end

    assign err_abs = 17'(r_err < 0 ? -r_err : r_err);
    assign recip_p = 53'(r_prod) * 53'(RECIP_100);
    assign q_s     = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign left_d  = 21'(q_s) + $signed({4'd0, r_base});
    assign right_d = 21'(q_s) - $signed({4'd0, r_base});

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sx        <= 10'd100;
            r_sy        <= 10'd100;
            r_gain      <= 10'd200;
            r_base      <= '0;
            r_leg       <= '0;
            r_pass      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                unique case (paddr[3:2])
                    REG_SX:   r_sx   <= pwdata[9:0];
                    REG_SY:   r_sy   <= pwdata[9:0];
                    REG_GAIN: r_gain <= pwdata[9:0];
                    REG_BASE: r_base <= pwdata[16:0];
                    default:  ;
                endcase
            end
            if (r_out_valid && i_m_tready && r_state != ST_DONE)
                r_out_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_x     <= i_s_tdata[15:0];
                        r_y     <= i_s_tdata[31:16];
                        r_h     <= i_s_tdata[47:32];
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_sxk    <= KW'(r_sx * r_pass);
                    r_syk    <= KW'(r_sy * r_pass);
                    r_op_leg <= r_leg;
                    r_state  <= ST_LEG;
                end
                ST_LEG: begin
                    unique case (r_leg)
                        2'd0: if (xs > WW'(400) + sxk) r_leg <= 2'd1;
                        2'd1: if (ys > WW'(3200) + syk) r_leg <= 2'd2;
                        2'd2: if (xs < -WW'(400) - sxk) r_leg <= 2'd3;
                        default: begin
                            if (ys < WW'(1600) - syk) begin
                                r_leg <= 2'd0;
                                if (r_pass < 8'(PASS_CAP)) begin
                                    r_pass <= r_pass + 8'd1;
                                    r_sxk  <= r_sxk + KW'(r_sx);
                                    r_syk  <= r_syk + KW'(r_sy);
                                end
                            end
                        end
                    endcase
                    r_state <= ST_ND;
                end
                ST_ND: begin
                    r_num   <= num_c;
                    r_den   <= den_c;
                    r_keep  <= (d1 == 0);
                    r_dxpos <= (d1 > 0);
                    r_state <= ST_CST;
                end
                ST_CST: r_state <= ST_CWAIT;
                ST_CWAIT: begin
                    if (c_done) begin
                        if (r_den == 0)
                            r_t <= (r_num > 0) ? 15'sd9000 : ((r_num < 0) ? -15'sd9000 : 15'sd0);
                        else if (r_num == 0)
                            r_t <= '0;
                        else if ((r_num < 0) != (r_den < 0))
                            r_t <= -$signed({1'b0, c_mag});
                        else
                            r_t <= $signed({1'b0, c_mag});
                        r_state <= ST_AIM;
                    end
                end
                ST_AIM: begin
                    r_last  <= aim;
                    r_err   <= err_w;
                    r_state <= ST_PROD;
                end
                ST_PROD: begin
                    r_prod  <= 25'(r_gain * err_abs);
                    r_neg   <= (r_err < 0);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_q     <= 18'(recip_p >> RECIP_SHIFT);
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out       <= {3'd0, r_pass, r_leg, 17'(r_err), right_d, left_d};
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_pass_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass >= $past(r_pass))
        else $error("pass count decreased");

    a_leg_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leg == $past(r_leg) || r_leg == $past(r_leg) + 2'd1)
        else $error("leg skipped");

    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> r_state == ST_CWAIT)
        else $error("cordic finished outside wait step");

endmodule
